### sv/lahs_pkg.sv
// Shared types and codes for the lattice hop step block.
package lahs_pkg;

   localparam int DIM_MAX    = 32;
   localparam int SITE_COUNT = 32768;

   localparam logic [1:0] REQ_SITE_LOAD = 2'd0;
   localparam logic [1:0] REQ_EDGE_LOAD = 2'd1;
   localparam logic [1:0] REQ_HOP       = 2'd2;
   localparam logic [1:0] REQ_RSVD      = 2'd3;

   localparam logic [2:0] ACT_NONE    = 3'd0;
   localparam logic [2:0] ACT_ADDED   = 3'd1;
   localparam logic [2:0] ACT_MOVED   = 3'd2;
   localparam logic [2:0] ACT_REMOVED = 3'd3;
   localparam logic [2:0] ACT_NO_CAND = 3'd4;
   localparam logic [2:0] ACT_LOADED  = 3'd5;

   localparam logic [2:0] DIR_XM = 3'd0;
   localparam logic [2:0] DIR_XP = 3'd1;
   localparam logic [2:0] DIR_YM = 3'd2;
   localparam logic [2:0] DIR_YP = 3'd3;
   localparam logic [2:0] DIR_ZM = 3'd4;
   localparam logic [2:0] DIR_ZP = 3'd5;

   localparam logic [2:0] REG_SIZE_X     = 3'd0;
   localparam logic [2:0] REG_SIZE_Y     = 3'd1;
   localparam logic [2:0] REG_SIZE_Z     = 3'd2;
   localparam logic [2:0] REG_EDGE_COUNT = 3'd3;
   localparam logic [2:0] REG_ADD_THR    = 3'd4;
   localparam logic [2:0] REG_RM_THR     = 3'd5;

   localparam int DIV_BITS = 31;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [4:0]  site_x;
      logic [4:0]  site_y;
      logic [4:0]  site_z;
      logic        hole_flag;
      logic        edge_flag;
      logic [14:0] entry_index;
      logic [2:0]  direction;
      logic [30:0] pick_draw;
      logic [15:0] add_draw;
      logic [15:0] remove_draw;
   } req_type_t_type;

   typedef struct packed {
      logic [2:0]  action;
      logic [4:0]  target_x;
      logic [4:0]  target_y;
      logic [4:0]  target_z;
      logic [15:0] fill_total;
   } rsp_type_t_type;

   // control between sequencer and modulo unit
   typedef struct packed {
      logic start;
      logic busy;
      logic done;
   } div_ctl_type;

endpackage

### sv/lahs_if.sv
// Valid/ready channel interfaces for requests and results.
interface lahs_req_if import lahs_pkg::*; ();
   logic           valid;
   logic           ready;
   req_type_t_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface lahs_rsp_if import lahs_pkg::*; ();
   logic           valid;
   logic           ready;
   rsp_type_t_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

### sv/lahs_mod_unit.sv
// Bit-serial remainder unit: one restoring step per cycle.
module lahs_mod_unit import lahs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [30:0] dividend,
   input  logic [16:0] divisor,
   output div_ctl_type ctl,
   output logic [16:0] remainder
);
   logic [30:0] quo_ff, quo_in;
   logic [17:0] rem_ff, rem_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [17:0] trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[16:0], quo_ff[30]};
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         cnt_in  = 5'(DIV_BITS - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[29:0], 1'b0};
         if (trial >= {1'b0, divisor}) rem_in = trial - {1'b0, divisor};
         else rem_in = trial;
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign remainder = rem_ff[16:0];
   assign ctl.start = start;
   assign ctl.busy  = busy_ff;
   assign ctl.done  = done_ff;

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      ctl.done |-> $past(busy_ff)) else $error("done without busy");
   a_rem_below: assert property (@(posedge clock) disable iff (reset)
      ctl.done |-> (rem_ff < {1'b0, $past(divisor)}))
      else $error("remainder not reduced");
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !start) else $error("restart while busy");
endmodule

### sv/lattice_atom_hop_step_core.sv
// Top level of the lattice hop step block: sequencer, memories and CSRs.
// After reset the block sweeps the site flag memory to zero over all
// SITE_COUNT (32768) sites and accepts no item meanwhile. One item is in
// flight at a time, and the next is accepted the cycle after the result has
// been taken. A reserved request or a hop with no candidates is answered
// from the idle state, a load item from the load state. A hop reduces the
// pick draw in a bit-serial remainder unit (start, 31 steps, done), then
// passes through the list read, the source decode with the source flag
// read, the neighbor flag read and the decision; a move then clears the
// fill bit of the source, and a removal reads the fill list tail and copies
// it down. An invalid direction or a failed add draw ends after the
// remainder, a neighbor off the lattice after the source decode.
module lattice_atom_hop_step_core import lahs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   lahs_req_if.sink    req,
   lahs_rsp_if.source  rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   localparam int DB = $clog2(DIM_MAX);
   localparam int NB = 3 * DB;
   localparam int AB = $clog2(SITE_COUNT);
   localparam int CB = AB + 1;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_CLEAR = 4'd1;
   localparam logic [3:0] S_DIV   = 4'd2;
   localparam logic [3:0] S_LIST  = 4'd3;
   localparam logic [3:0] S_SRC   = 4'd4;
   localparam logic [3:0] S_NBR   = 4'd5;
   localparam logic [3:0] S_DEC   = 4'd6;
   localparam logic [3:0] S_TAIL  = 4'd7;
   localparam logic [3:0] S_RMWR  = 4'd8;
   localparam logic [3:0] S_OUT   = 4'd9;
   localparam logic [3:0] S_LOAD  = 4'd10;

   // memories
   logic [2:0]    flag_mem [SITE_COUNT];
   logic [AB-1:0] edge_mem [SITE_COUNT];
   logic [AB-1:0] fill_mem [SITE_COUNT];
   logic [2:0]    flag_rd_ff;
   logic [AB-1:0] edge_rd_ff, fill_rd_ff;
   logic          flag_we, edge_we, fill_we;
   logic [AB-1:0] flag_addr, edge_addr, fill_addr;
   logic [2:0]    flag_wd;
   logic [AB-1:0] edge_wd, fill_wd;

   // config
   logic [5:0]  size_x_ff, size_y_ff, size_z_ff;
   logic [15:0] edge_count_ff;
   logic [16:0] add_thr_ff, rm_thr_ff;
   logic        csr_wr;
   logic [2:0]  csr_idx;

   logic [3:0]     state_ff, state_in;
   req_type_t_type item_ff, item_in;
   rsp_type_t_type out_ff, out_in;
   logic           out_valid_ff, out_valid_in;
   logic [CB-1:0]  fill_count_ff, fill_count_in;
   logic [AB-1:0]  clr_ff, clr_in;
   logic [16:0]    sel_ff, sel_in;
   logic           from_edge_ff, from_edge_in;
   logic [AB-1:0]  src_ff, src_in, nb_ff, nb_in;
   logic [1:0]     src_fl_ff, src_fl_in;
   logic           fail_ff, fail_in;

   logic           div_start;
   div_ctl_type    div_ctl;
   logic [16:0]    rem;
   logic [16:0]    avail;
   logic [16:0]    fsel;
   logic [DB:0]    ex, ey, ez;
   logic [DB+1:0]  cx, cy, cz;

   assign avail = {1'b0, edge_count_ff} + 17'(fill_count_ff);
   assign fsel  = sel_ff - {1'b0, edge_count_ff};

   lahs_mod_unit u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (item_ff.pick_draw),
      .divisor   (avail),
      .ctl       (div_ctl),
      .remainder (rem)
   );

   function automatic logic [DB:0] ext(input logic [5:0] s);
      if (32'(s) < DIM_MAX) return (DB+1)'(s);
      return (DB+1)'(DIM_MAX);
   endfunction

   assign ex = ext(size_x_ff);
   assign ey = ext(size_y_ff);
   assign ez = ext(size_z_ff);

   // CSR port
   assign csr_pready = 1'b1;
   assign csr_wr  = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx = csr_paddr[4:2];
   always_comb begin
      case (csr_idx)
         REG_SIZE_X:     csr_prdata = 32'(size_x_ff);
         REG_SIZE_Y:     csr_prdata = 32'(size_y_ff);
         REG_SIZE_Z:     csr_prdata = 32'(size_z_ff);
         REG_EDGE_COUNT: csr_prdata = 32'(edge_count_ff);
         REG_ADD_THR:    csr_prdata = 32'(add_thr_ff);
         REG_RM_THR:     csr_prdata = 32'(rm_thr_ff);
         default:        csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_x_ff     <= 6'd32;
         size_y_ff     <= 6'd32;
         size_z_ff     <= 6'd32;
         edge_count_ff <= '0;
         add_thr_ff    <= '0;
         rm_thr_ff     <= '0;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_SIZE_X:     size_x_ff     <= csr_pwdata[5:0];
            REG_SIZE_Y:     size_y_ff     <= csr_pwdata[5:0];
            REG_SIZE_Z:     size_z_ff     <= csr_pwdata[5:0];
            REG_EDGE_COUNT: edge_count_ff <= csr_pwdata[15:0];
            REG_ADD_THR:    add_thr_ff    <= csr_pwdata[16:0];
            REG_RM_THR:     rm_thr_ff     <= csr_pwdata[16:0];
            default: ;
         endcase
      end
   end

   // memory ports
   always_ff @(posedge clock) begin
      if (flag_we) flag_mem[flag_addr] <= flag_wd;
      flag_rd_ff <= flag_mem[flag_addr];
      if (edge_we) edge_mem[edge_addr] <= edge_wd;
      edge_rd_ff <= edge_mem[edge_addr];
      if (fill_we) fill_mem[fill_addr] <= fill_wd;
      fill_rd_ff <= fill_mem[fill_addr];
   end

   assign req.ready = (state_ff == S_IDLE) && !out_valid_ff;
   assign rsp.valid = out_valid_ff;
   assign rsp.payload = out_ff;

   function automatic rsp_type_t_type mk(input logic [2:0] a, input logic [AB-1:0] s,
                                         input logic [CB-1:0] fc);
      rsp_type_t_type r;
      r.action     = a;
      r.target_x   = 5'(s[AB-1 -: DB] & {DB{1'b1}});
      r.target_y   = 5'(s[2*DB-1 -: DB]);
      r.target_z   = 5'(s[DB-1:0]);
      r.fill_total = 16'(fc);
      return r;
   endfunction

   always_comb begin
      state_in      = state_ff;
      item_in       = item_ff;
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      fill_count_in = fill_count_ff;
      clr_in        = clr_ff;
      sel_in        = sel_ff;
      from_edge_in  = from_edge_ff;
      src_in        = src_ff;
      nb_in         = nb_ff;
      src_fl_in     = src_fl_ff;
      fail_in       = fail_ff;
      div_start = 1'b0;
      flag_we = 1'b0; flag_addr = nb_ff; flag_wd = '0;
      edge_we = 1'b0; edge_addr = sel_ff[AB-1:0]; edge_wd = '0;
      fill_we = 1'b0; fill_addr = fsel[AB-1:0]; fill_wd = nb_ff;
      cx = '0; cy = '0; cz = '0;

      if (rsp.valid && rsp.ready) out_valid_in = 1'b0;

      case (state_ff)
         S_CLEAR: begin
            flag_we = 1'b1; flag_addr = clr_ff; flag_wd = '0;
            clr_in = clr_ff + 1'b1;
            if (32'(clr_ff) == SITE_COUNT - 1) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req.valid && req.ready) begin
               item_in = req.payload;
               case (req.payload.req_type)
                  REQ_SITE_LOAD, REQ_EDGE_LOAD: state_in = S_LOAD;
                  REQ_HOP: begin
                     if (avail == '0) begin
                        out_in = mk(ACT_NO_CAND, '0, fill_count_ff);
                        out_valid_in = 1'b1;
                     end else state_in = S_DIV;
                  end
                  default: begin
                     out_in = mk(ACT_NONE, '0, fill_count_ff);
                     out_valid_in = 1'b1;
                  end
               endcase
            end
         end
         S_LOAD: begin
            if (item_ff.req_type == REQ_SITE_LOAD) begin
               flag_addr = AB'({item_ff.site_x, item_ff.site_y, item_ff.site_z});
               flag_wd = {1'b0, item_ff.edge_flag, item_ff.hole_flag};
               flag_we = (32'(item_ff.site_x) < DIM_MAX) &&
                  (32'(item_ff.site_y) < DIM_MAX) && (32'(item_ff.site_z) < DIM_MAX) &&
                  ((32'(item_ff.site_x) * DIM_MAX + 32'(item_ff.site_y)) * DIM_MAX +
                   32'(item_ff.site_z) < SITE_COUNT);
            end else begin
               edge_addr = AB'(item_ff.entry_index);
               edge_wd = AB'({item_ff.site_x, item_ff.site_y, item_ff.site_z});
               edge_we = 32'(item_ff.entry_index) < SITE_COUNT;
            end
            out_in = '0;
            out_in.action = ACT_LOADED;
            out_in.target_x = item_ff.site_x;
            out_in.target_y = item_ff.site_y;
            out_in.target_z = item_ff.site_z;
            out_in.fill_total = 16'(fill_count_ff);
            out_valid_in = 1'b1;
            state_in = S_IDLE;
         end
         S_DIV: begin
            if (!div_ctl.busy && !div_ctl.done) div_start = 1'b1;
            if (div_ctl.done) begin
               sel_in = rem;
               from_edge_in = rem < {1'b0, edge_count_ff};
               if (item_ff.direction > DIR_ZP ||
                   (rem < {1'b0, edge_count_ff} && {1'b0, item_ff.add_draw} >= add_thr_ff))
               begin
                  out_in = mk(ACT_NONE, '0, fill_count_ff);
                  out_valid_in = 1'b1;
                  state_in = S_IDLE;
               end else state_in = S_LIST;
            end
         end
         S_LIST: begin
            // list read address is presented this cycle; data lands next
            fail_in = from_edge_ff ? (32'(sel_ff) >= SITE_COUNT) : (32'(fsel) >= SITE_COUNT);
            state_in = S_SRC;
         end
         S_SRC: begin
            src_in = fail_ff ? '0 : (from_edge_ff ? edge_rd_ff : fill_rd_ff);
            // fetch the source flags so a later clear keeps its hole and edge bits
            flag_addr = src_in;
            cx = (DB+2)'(src_in[NB-1 -: DB]);
            cy = (DB+2)'(src_in[2*DB-1 -: DB]);
            cz = (DB+2)'(src_in[DB-1:0]);
            case (item_ff.direction)
               DIR_XM: cx = cx - 1'b1;
               DIR_XP: cx = cx + 1'b1;
               DIR_YM: cy = cy - 1'b1;
               DIR_YP: cy = cy + 1'b1;
               DIR_ZM: cz = cz - 1'b1;
               default: cz = cz + 1'b1;
            endcase
            nb_in = AB'({cx[DB-1:0], cy[DB-1:0], cz[DB-1:0]});
            if (cx[DB+1] || cy[DB+1] || cz[DB+1] ||
                cx[DB:0] >= ex || cy[DB:0] >= ey || cz[DB:0] >= ez) begin
               out_in = mk(ACT_NONE, '0, fill_count_ff);
               out_valid_in = 1'b1;
               state_in = S_IDLE;
            end else state_in = S_NBR;
         end
         S_NBR: begin
            src_fl_in = flag_rd_ff[1:0];
            flag_addr = nb_ff;
            state_in = S_DEC;
         end
         S_DEC: begin
            state_in = S_OUT;
            out_in = mk(ACT_NONE, '0, fill_count_ff);
            if (from_edge_ff) begin
               if (flag_rd_ff == '0 && 32'(fill_count_ff) < SITE_COUNT) begin
                  flag_we = 1'b1; flag_addr = nb_ff; flag_wd = 3'b100;
                  fill_we = 1'b1; fill_addr = fill_count_ff[AB-1:0]; fill_wd = nb_ff;
                  fill_count_in = fill_count_ff + 1'b1;
                  out_in = mk(ACT_ADDED, nb_ff, fill_count_in);
               end
            end else if (flag_rd_ff[1:0] != '0) begin
               if ({1'b0, item_ff.remove_draw} < rm_thr_ff) begin
                  flag_we = 1'b1; flag_addr = src_ff; flag_wd = {1'b0, src_fl_ff};
                  fill_count_in = fill_count_ff - 1'b1;
                  out_in = mk(ACT_REMOVED, src_ff, fill_count_in);
                  state_in = S_TAIL;
               end
            end else if (!flag_rd_ff[2]) begin
               flag_we = 1'b1; flag_addr = nb_ff; flag_wd = {1'b1, flag_rd_ff[1:0]};
               fill_we = 1'b1; fill_wd = nb_ff;
               out_in = mk(ACT_MOVED, nb_ff, fill_count_ff);
               state_in = S_RMWR;
            end
         end
         S_RMWR: begin
            // drop the fill bit of the source after a move
            flag_we = 1'b1; flag_addr = src_ff; flag_wd = {1'b0, src_fl_ff};
            state_in = S_OUT;
         end
         S_TAIL: begin
            fill_addr = fill_count_ff[AB-1:0];
            fail_in = 1'b1;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (fail_ff && out_in.action == ACT_REMOVED) begin
               fill_we = 1'b1; fill_wd = fill_rd_ff;
               fail_in = 1'b0;
            end else begin
               out_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      out_ff  <= out_in;
      sel_ff  <= sel_in;
      from_edge_ff <= from_edge_in;
      src_ff  <= src_in;
      nb_ff   <= nb_in;
      src_fl_ff <= src_fl_in;
      fail_ff <= fail_in;
      if (reset) begin
         state_ff      <= S_CLEAR;
         out_valid_ff  <= 1'b0;
         fill_count_ff <= '0;
         clr_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         out_valid_ff  <= out_valid_in;
         fill_count_ff <= fill_count_in;
         clr_ff        <= clr_in;
      end
   end

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      32'(fill_count_ff) <= SITE_COUNT) else $error("fill count overflow");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req.ready) else $error("ready while busy");
   a_fill_step: assert property (@(posedge clock) disable iff (reset)
      (fill_count_ff != $past(fill_count_ff)) |-> ($past(state_ff) == S_DEC))
      else $error("fill count changed outside decision");
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ready) |=> rsp.valid) else $error("result dropped");
endmodule
